// ===== rtl/core/pdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdsd_pkg: shared types, constants and tables of the PD position SPWM driver
// Holds register indexes, field widths, the word types and the sine table.
// ----------------------------------------------------------------------------
package pdsd_pkg;

  localparam int unsigned PolePairsDefault = 11;

  // Configuration register indexes
  localparam logic [1:0] RegKpGain      = 2'd0;
  localparam logic [1:0] RegKdGain      = 2'd1;
  localparam logic [1:0] RegTorqueLimit = 2'd2;
  localparam logic [1:0] RegSyncOffset  = 2'd3;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Lead codes
  localparam logic [1:0] LeadNone = 2'd0;
  localparam logic [1:0] Lead90   = 2'd1;
  localparam logic [1:0] Lead270  = 2'd2;

  typedef struct packed {
    logic [9:0]  setpoint_raw;
    logic [11:0] sensor_angle;
    logic [15:0] elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [7:0] duty_c;
    logic [6:0] torque_pct;
    logic [1:0] field_lead;
  } out_word_t;

  // Classified tick handed from front to back
  typedef struct packed {
    logic signed [10:0] err;      // angle - setpoint, -360..359
    logic signed [11:0] derr;     // err - last error
    logic [15:0]        e;        // elapsed, zero forced to one
    logic [8:0]         ang_deg;  // angle in degrees
    logic [1:0]         lead;
  } task_t;

  typedef enum logic [3:0] {
    BkIdle, BkMulA, BkMulB, BkSum, BkDiv, BkClamp, BkElec, BkSine, BkDuty, BkOut
  } bk_state_e;

  // floor(255*sin(d)) for d = 0..90
  function automatic logic [7:0] sin255(input logic [6:0] d);
    logic [7:0] t [0:90];
    t = '{
      8'd0,8'd4,8'd8,8'd13,8'd17,8'd22,8'd26,8'd31,8'd35,8'd39,
      8'd44,8'd48,8'd53,8'd57,8'd61,8'd65,8'd70,8'd74,8'd78,8'd83,
      8'd87,8'd91,8'd95,8'd99,8'd103,8'd107,8'd111,8'd115,8'd119,8'd123,
      8'd127,8'd131,8'd135,8'd138,8'd142,8'd146,8'd149,8'd153,8'd156,8'd160,
      8'd163,8'd167,8'd170,8'd173,8'd177,8'd180,8'd183,8'd186,8'd189,8'd192,
      8'd195,8'd198,8'd200,8'd203,8'd206,8'd208,8'd211,8'd213,8'd216,8'd218,
      8'd220,8'd223,8'd225,8'd227,8'd229,8'd231,8'd232,8'd234,8'd236,8'd238,
      8'd239,8'd241,8'd242,8'd243,8'd245,8'd246,8'd247,8'd248,8'd249,8'd250,
      8'd251,8'd251,8'd252,8'd253,8'd253,8'd254,8'd254,8'd254,8'd254,8'd254,
      8'd255};
    if (d > 7'd90) return 8'd0;
    return t[d];
  endfunction

  // Sine level for deg in 0..359
  function automatic logic [7:0] sine_level(input logic [8:0] deg);
    logic [8:0] q, r;
    logic [8:0] y;
    q = (deg >= 9'd180) ? deg - 9'd180 : deg;
    r = (q <= 9'd90) ? q : 9'd180 - q;
    y = {1'b0, sin255(r[6:0])};
    if (deg < 9'd180) return 8'((9'd255 + y) >> 1);
    if (r != 9'd0 && r != 9'd90) y = y + 9'd1;
    return 8'((9'd255 - y) >> 1);
  endfunction

endpackage

// ===== rtl/core/pdsd_if.sv =====
// ----------------------------------------------------------------------------
// pdsd_if: valid/ready channel
// Carries one word of a generic payload type.
// ----------------------------------------------------------------------------
interface pdsd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pdsd_front.sv =====
// ----------------------------------------------------------------------------
// pdsd_front: input classification
// Converts setpoint and angle to degrees, forms the error, updates the lead
// code and last error, and pushes a task word into the queue.
// ----------------------------------------------------------------------------
module pdsd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pdsd_pkg::in_word_t in_data_i,
  output logic             push_o,
  output pdsd_pkg::task_t  task_o,
  input  logic             full_i
);
  import pdsd_pkg::*;

  logic signed [10:0] last_err_q, last_err_d;
  logic [1:0]         lead_q, lead_d;
  logic [19:0]        sp_prod;
  logic [20:0]        ang_prod;
  logic [8:0]         sp_deg, ang_deg;
  logic signed [10:0] err;
  logic [29:0]        sp_recip;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Degree conversion: sp*360/1023 via reciprocal with one correction
  always_comb begin
    sp_prod  = 20'(in_data_i.setpoint_raw) * 20'd360;
    sp_recip = (30'(sp_prod) * 30'd1025) >> 20;
    sp_deg   = 9'(sp_recip);
    if (20'(sp_deg) * 20'd1023 + 20'd1023 <= sp_prod) sp_deg = sp_deg + 9'd1;
    ang_prod = 21'(in_data_i.sensor_angle) * 21'd360;
    ang_deg  = 9'(ang_prod >> 12);
    err      = $signed({2'b0, ang_deg}) - $signed({2'b0, sp_deg});
  end

  // Lead and last error update
  always_comb begin
    lead_d = lead_q;
    if (err < 0) lead_d = Lead90;
    else if (err > 0) lead_d = Lead270;
    last_err_d = err;
    task_o.err     = err;
    task_o.derr    = 12'(err) - 12'(last_err_q);
    task_o.e       = (in_data_i.elapsed_ms == 16'd0) ? 16'd1 : in_data_i.elapsed_ms;
    task_o.ang_deg = ang_deg;
    task_o.lead    = lead_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      lead_q     <= LeadNone;
    end else if (push_o) begin
      last_err_q <= last_err_d;
      lead_q     <= lead_d;
    end
  end
endmodule

// ===== rtl/core/pdsd_queue.sv =====
// ----------------------------------------------------------------------------
// pdsd_queue: two-entry task queue
// Decouples the front from the back.
// ----------------------------------------------------------------------------
module pdsd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pdsd_pkg::task_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pdsd_pkg::task_t data_o
);
  import pdsd_pkg::*;

  task_t       mem_q [0:1];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// ===== rtl/core/pdsd_back.sv =====
// ----------------------------------------------------------------------------
// pdsd_back: PD torque and SPWM duty sequencer
// Computes the PD numerator, divides it by 256*e bit-serially, clamps, then
// builds the electrical angle and the three duties.
// ----------------------------------------------------------------------------
module pdsd_back #(
  parameter int unsigned PolePairs = pdsd_pkg::PolePairsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  pdsd_pkg::task_t   task_i,
  output logic              pop_o,
  input  logic [15:0]       kp_i,
  input  logic [15:0]       kd_i,
  input  logic [6:0]        limit_i,
  input  logic [8:0]        offset_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pdsd_pkg::out_word_t out_data_o
);
  import pdsd_pkg::*;

  localparam int unsigned MagW = 45;
  localparam int unsigned PpW  = $clog2(PolePairs + 1);
  localparam int unsigned ElW  = 9 + PpW + 1;

  bk_state_e state_q, state_d;
  task_t     t_q;
  logic signed [27:0] p1_q;         // kp*err
  logic signed [44:0] num_q;
  logic [MagW-1:0]    rem_q, quo_q;
  logic [5:0]         cnt_q;
  logic [23:0]        div_q;        // 256*e
  logic [6:0]         torque_q;
  logic [8:0]         elec_q;
  logic [ElW-1:0]     el_q;
  logic [7:0]         sa_q, sb_q, sc_q;
  logic [1:0]         ph_q;
  logic [7:0]         duty_q [0:2];
  logic               ov_q;
  out_word_t          od_q;

  logic [MagW:0]      trial;
  logic [14:0]        dprod;
  logic [27:0]        dq;           // dprod * ceil(2^19/100)
  logic [7:0]         dsel;
  logic [6:0]         lim;
  logic [8:0]         lead_deg;
  logic [9:0]         pb, pc;

  always_comb begin
    case (state_q)
      BkIdle:  state_d = (!empty_i && !ov_q) ? BkMulA : BkIdle;
      BkMulA:  state_d = BkMulB;
      BkMulB:  state_d = BkSum;
      BkSum:   state_d = BkDiv;
      BkDiv:   state_d = (cnt_q == 6'd0) ? BkClamp : BkDiv;
      BkClamp: state_d = BkElec;
      BkElec:  state_d = (el_q < ElW'(360)) ? BkSine : BkElec;
      BkSine:  state_d = BkDuty;
      BkDuty:  state_d = (ph_q == 2'd2) ? BkOut : BkDuty;
      BkOut:   state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  assign pop_o = (state_q == BkIdle) && !empty_i && !ov_q;

  always_comb begin
    trial    = {rem_q, quo_q[MagW-1]} - (MagW+1)'(div_q);
    lim      = (limit_i > 7'd100) ? 7'd100 : limit_i;
    lead_deg = (t_q.lead == Lead90) ? 9'd90 : (t_q.lead == Lead270) ? 9'd270 : 9'd0;
    pb       = 10'(elec_q) + 10'd120;
    pc       = 10'(elec_q) + 10'd240;
    if (pb >= 10'd360) pb = pb - 10'd360;
    if (pc >= 10'd360) pc = pc - 10'd360;
    case (ph_q)
      2'd0:    dsel = sa_q;
      2'd1:    dsel = sb_q;
      default: dsel = sc_q;
    endcase
    dprod = 15'(dsel) * 15'(torque_q);
    // exact floor(dprod/100) for dprod up to 25500
    dq    = 28'(dprod) * 28'd5243;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        t_q <= task_i;
      end
      BkMulA: p1_q <= $signed({1'b0, kp_i}) * t_q.err;
      BkMulB: num_q <= 45'(p1_q) * 45'($signed({1'b0, t_q.e}))
                     + 45'($signed({1'b0, kd_i})) * 45'(t_q.derr);
      BkSum: begin
        quo_q <= num_q[44] ? MagW'(-num_q) : MagW'(num_q);
        rem_q <= '0;
        div_q <= {t_q.e, 8'd0};
        cnt_q <= 6'(MagW - 1);
      end
      BkDiv: begin
        // restoring division, one quotient bit a cycle
        if (!trial[MagW]) begin
          rem_q <= trial[MagW-1:0];
          quo_q <= {quo_q[MagW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[MagW-2:0], quo_q[MagW-1]};
          quo_q <= {quo_q[MagW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
      end
      BkClamp: begin
        torque_q <= (quo_q > MagW'(lim)) ? lim : quo_q[6:0];
        el_q <= ElW'(t_q.ang_deg) * ElW'(PolePairs) + ElW'(lead_deg) + ElW'(offset_i);
      end
      BkElec: begin
        if (el_q >= ElW'(360)) el_q <= el_q - ElW'(360);
        else elec_q <= el_q[8:0];
        ph_q <= 2'd0;
      end
      BkSine: begin
        sa_q <= sine_level(elec_q);
        sb_q <= sine_level(pb[8:0]);
        sc_q <= sine_level(pc[8:0]);
      end
      BkDuty: begin
        duty_q[ph_q] <= dq[26:19];
        ph_q <= ph_q + 2'd1;
      end
      default: ;
    endcase
    if (state_q == BkOut) begin
      od_q.duty_a <= duty_q[0];
      od_q.duty_b <= duty_q[1];
      od_q.duty_c <= duty_q[2];
      od_q.torque_pct <= torque_q;
      od_q.field_lead <= t_q.lead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BkOut) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
endmodule

// ===== rtl/core/pd_position_spwm_driver_core.sv =====
// ----------------------------------------------------------------------------
// pd_position_spwm_driver_core: PD position loop with three-phase SPWM
// Top level: config registers, front classifier, queue and back sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one tick word (setpoint, angle, elapsed ms); out_if returns
//   one word per tick (three duties, torque percent, lead code).
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
//   this is up to the user, since the block itself has no check for it;
//   indexes past the list are ignored.
//   The back sequencer wraps the electrical angle by subtracting 360 degrees
//   until it lies below 360, and runs the 45-step restoring divider; it
//   handles one word at a time and starts the next only after the receiver
//   has taken the last result.
//   The front accepts words whenever the two-entry queue has room, so up to
//   two ticks can be queued while a result waits.
//   Reset clears the last error, the lead code, the queue and the output
//   valid, and loads the register reset values.
//   When the receiver stalls the result holds in the output register and the
//   back stops; the front keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module pd_position_spwm_driver_core #(
  parameter int unsigned PolePairs = pdsd_pkg::PolePairsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pdsd_if.sink                          in_if,
  pdsd_if.source                        out_if,
  input  logic                          cfg_we_i,
  input  logic [pdsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pdsd_pkg::CfgDataW-1:0] cfg_data_i
);
  import pdsd_pkg::*;

  logic [15:0] kp_q, kd_q;
  logic [6:0]  lim_q;
  logic [8:0]  off_q;
  logic        push, full, pop, empty;
  task_t       tin, tout;
  out_word_t   od;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= 16'd6400; kd_q <= 16'd8192; lim_q <= 7'd100; off_q <= 9'd21;
    end else if (cfg_we_i && cfg_idx_i[CfgIdxW-1:2] == '0) begin
      case (cfg_idx_i[1:0])
        RegKpGain:      kp_q  <= cfg_data_i;
        RegKdGain:      kd_q  <= cfg_data_i;
        RegTorqueLimit: lim_q <= cfg_data_i[6:0];
        RegSyncOffset:  off_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  pdsd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .push_o(push), .task_o(tin), .full_i(full)
  );

  pdsd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(tin), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(tout)
  );

  pdsd_back #(.PolePairs(PolePairs)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .task_i(tout), .pop_o(pop),
    .kp_i(kp_q), .kd_i(kd_q), .limit_i(lim_q), .offset_i(off_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(od)
  );
  assign out_if.data = od;

  // Assertions
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_torque_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> od.torque_pct <= 7'd100) else $error("torque above 100");
endmodule
